### hdl/uml_pkg.sv
package uml_pkg;

   localparam int MAX_RADIUS    = 12;
   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int TAP_BITS      = 12;
   localparam int GAIN_FRAC     = 12;
   localparam int SAMPLE_BITS   = 16;
   localparam int VSUM_BITS     = 24;
   localparam int THRESH_BITS   = 15;
   localparam int GAIN_BITS     = 16;
   localparam int RAD_BITS      = 4;
   localparam int DIM_BITS      = 13;
   localparam int NEAR_BITS     = 60;
   localparam int FAR_BITS      = 36;
   localparam int TAPS_BITS     = NEAR_BITS + NEAR_BITS + FAR_BITS;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = $clog2(MAX_HEIGHT + MAX_RADIUS + 2);
   localparam int WIN_LEN       = 2 * MAX_RADIUS + 1;
   localparam int WIN_IDX_BITS  = $clog2(WIN_LEN);
   localparam int STORE_DEPTH   = 2 * MAX_RADIUS * MAX_WIDTH;
   localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
   localparam int LAG_BITS      = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
   localparam int POS_BITS      =
      $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int CSR_DATA_BITS = 60;
   localparam int CSR_IDX_BITS  = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_TAPS_NEAR   = 3'd0,
      CSR_TAPS_MIDDLE = 3'd1,
      CSR_TAPS_FAR    = 3'd2,
      CSR_RADIUS      = 3'd3,
      CSR_THRESHOLD   = 3'd4,
      CSR_GAIN        = 3'd5,
      CSR_WIDTH       = 3'd6,
      CSR_HEIGHT      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [ADDR_BITS-1:0]          waddr;
      logic                          store;
      logic                          emit;
      logic                          pass;
      logic                          last;
   } item_type;

   typedef struct packed {
      logic [RAD_BITS-1:0] radius;
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;
      logic [LAG_BITS-1:0] lag;
      logic [POS_BITS-1:0] end_pos;
   } front_cfg_type;

   typedef struct packed {
      logic [TAPS_BITS-1:0]   taps;
      logic [RAD_BITS-1:0]    radius;
      logic [DIM_BITS-1:0]    width;
      logic [LAG_BITS-1:0]    lag;
      logic [THRESH_BITS-1:0] threshold;
      logic [GAIN_BITS-1:0]   gain;
   } back_cfg_type;

endpackage

### hdl/uml_ram.sv
module uml_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/uml_front.sv
module uml_front import uml_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  front_cfg_type                 cfg,
   input  logic                          hold,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_lightness_in,
   input  logic                          req_pad,
   input  logic                          q_full,
   output logic                          q_push,
   output item_type                      q_data
);

   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [COL_BITS-1:0]  ocol_ff, ocol_in;
   logic [ROW_BITS-1:0]  orow_ff, orow_in;

   logic accept, in_frame, emit, last, inner;

   assign req_ready = !q_full && !hold;
   assign accept    = req_valid && req_ready;
   assign in_frame  = (ROW_BITS + 1)'(row_ff) < (ROW_BITS + 1)'(cfg.height);
   assign q_push    = accept && !(req_pad && in_frame);

   assign emit = (pos_ff >= POS_BITS'(cfg.lag)) && (pos_ff < cfg.end_pos);
   assign last = (pos_ff == cfg.end_pos - POS_BITS'(1));

   assign inner = (cfg.radius != '0)
      && ((ROW_BITS + 1)'(orow_ff) >= (ROW_BITS + 1)'(cfg.radius))
      && ((ROW_BITS + 1)'(orow_ff) + (ROW_BITS + 1)'(cfg.radius)
          < (ROW_BITS + 1)'(cfg.height))
      && ((DIM_BITS + 1)'(ocol_ff) >= (DIM_BITS + 1)'(cfg.radius))
      && ((DIM_BITS + 1)'(ocol_ff) + (DIM_BITS + 1)'(cfg.radius)
          < (DIM_BITS + 1)'(cfg.width));

   always_comb begin
      q_data.sample = req_lightness_in;
      q_data.waddr  = addr_ff;
      q_data.store  = in_frame;
      q_data.emit   = emit;
      q_data.pass   = !inner;
      q_data.last   = last;
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pos_in  = pos_ff;
      addr_in = addr_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (q_push) begin
         pos_in  = pos_ff + POS_BITS'(1);
         addr_in = (addr_ff == ADDR_BITS'(STORE_DEPTH - 1)) ? '0 : addr_ff + ADDR_BITS'(1);
         if (DIM_BITS'(col_ff) + DIM_BITS'(1) >= cfg.width) begin
            col_in = '0;
            row_in = row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
         if (emit) begin
            if (DIM_BITS'(ocol_ff) + DIM_BITS'(1) >= cfg.width) begin
               ocol_in = '0;
               orow_in = orow_ff + ROW_BITS'(1);
            end else begin
               ocol_in = ocol_ff + COL_BITS'(1);
            end
            if (last) begin
               col_in  = '0;
               row_in  = '0;
               pos_in  = '0;
               addr_in = '0;
               ocol_in = '0;
               orow_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pos_ff  <= '0;
         addr_ff <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pos_ff  <= pos_in;
         addr_ff <= addr_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
      end
   end

endmodule

### hdl/uml_queue.sv
module uml_queue import uml_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   item_type slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   assign full     = (count_ff == (QPTR_BITS + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + QPTR_BITS'(1) : wptr_ff;
      rptr_in  = pop ? rptr_ff + QPTR_BITS'(1) : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_BITS + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### hdl/uml_back.sv
module uml_back import uml_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  back_cfg_type                  cfg,
   input  logic                          q_empty,
   input  item_type                      q_data,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_lightness_out,
   output logic                          rsp_frame_end
);

   localparam int VACC_BITS  = SAMPLE_BITS + TAP_BITS + WIN_IDX_BITS + 1;
   localparam int VQ_BITS    = VACC_BITS - TAP_BITS;
   localparam int VPROD_BITS = SAMPLE_BITS + TAP_BITS + 1;
   localparam int HPROD_BITS = VSUM_BITS + TAP_BITS + 1;
   localparam int HACC_BITS  = HPROD_BITS + WIN_IDX_BITS;
   localparam int HQ_BITS    = HACC_BITS - TAP_BITS;
   localparam int BLUR_BITS  = HQ_BITS + 1;
   localparam int DIFF_BITS  = BLUR_BITS + 1;
   localparam int PROD_BITS  = DIFF_BITS + GAIN_BITS + 1;
   localparam int PQ_BITS    = PROD_BITS - GAIN_FRAC;
   localparam int SUM_BITS   = PQ_BITS + 2;

   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001,
      S_VRD  = 12'b0000_0000_0010,
      S_VMAC = 12'b0000_0000_0100,
      S_VFIN = 12'b0000_0000_1000,
      S_ORD  = 12'b0000_0001_0000,
      S_ODAT = 12'b0000_0010_0000,
      S_HMAC = 12'b0000_0100_0000,
      S_HFIN = 12'b0000_1000_0000,
      S_DIFF = 12'b0001_0000_0000,
      S_THR  = 12'b0010_0000_0000,
      S_GMUL = 12'b0100_0000_0000,
      S_RES  = 12'b1000_0000_0000
   } state_type;

   function automatic logic [TAP_BITS-1:0] tap_at(input logic [TAPS_BITS-1:0] taps,
                                                   input logic [RAD_BITS-1:0] d);
      logic [TAPS_BITS-1:0] sh;
      sh = taps >> (int'(d) * TAP_BITS);
      if (int'(d) > MAX_RADIUS) begin
         return '0;
      end
      return sh[TAP_BITS-1:0];
   endfunction

   function automatic logic [ADDR_BITS-1:0] mod_sub(input logic [ADDR_BITS-1:0] a,
                                                     input logic [ADDR_BITS-1:0] b);
      logic [ADDR_BITS:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (d[ADDR_BITS]) begin
         d = d + (ADDR_BITS + 1)'(STORE_DEPTH);
      end
      return d[ADDR_BITS-1:0];
   endfunction

   state_type state_ff, state_in;
   item_type  ent_ff, ent_in;
   logic [WIN_IDX_BITS-1:0]       k_ff, k_in;
   logic [ADDR_BITS-1:0]          raddr_ff, raddr_in;
   logic signed [VACC_BITS-1:0]   vacc_ff, vacc_in;
   logic signed [HACC_BITS-1:0]   hacc_ff, hacc_in;
   logic signed [SAMPLE_BITS-1:0] orig_ff, orig_in;
   logic signed [BLUR_BITS-1:0]   blur_ff, blur_in;
   logic signed [DIFF_BITS-1:0]   diff_ff, diff_in;
   logic signed [DIFF_BITS-1:0]   detail_ff, detail_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [VSUM_BITS-1:0]   win_ff [WIN_LEN];
   logic signed [VSUM_BITS-1:0]   win_in [WIN_LEN];
   logic                          out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_data_ff, out_data_in;
   logic                          out_last_ff, out_last_in;

   logic                          ram_we;
   logic [ADDR_BITS-1:0]          ram_raddr;
   logic [SAMPLE_BITS-1:0]        ram_rdata;
   logic signed [SAMPLE_BITS-1:0] rd_sample;

   logic [WIN_IDX_BITS-1:0]       two_r, r_ext, dist_k;
   logic [ADDR_BITS-1:0]          width_addr, lag_addr;
   logic [TAP_BITS-1:0]           tap_k, tap_c;
   logic signed [VPROD_BITS-1:0]  vprod, cprod;
   logic signed [HPROD_BITS-1:0]  hprod;
   logic [VACC_BITS-1:0]          vmag;
   logic [VQ_BITS-1:0]            vq;
   logic signed [VSUM_BITS-1:0]   vq_ext, vsum;
   logic [HACC_BITS-1:0]          hmag;
   logic [HQ_BITS-1:0]            hq;
   logic signed [BLUR_BITS-1:0]   hq_ext;
   logic [DIFF_BITS-1:0]          dmag, thr_ext;
   logic signed [DIFF_BITS-1:0]   dpos;
   logic [PROD_BITS-1:0]          pmag;
   logic [PQ_BITS-1:0]            pq;
   logic signed [SUM_BITS-1:0]    pq_ext, adj, total;
   logic signed [SAMPLE_BITS-1:0] result;

   uml_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ent_ff.waddr),
      .wdata (ent_ff.sample),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_sample  = $signed(ram_rdata);
   assign two_r      = WIN_IDX_BITS'({cfg.radius, 1'b0});
   assign r_ext      = WIN_IDX_BITS'(cfg.radius);
   assign dist_k     = (k_ff > r_ext) ? k_ff - r_ext : r_ext - k_ff;
   assign tap_k      = tap_at(cfg.taps, RAD_BITS'(dist_k));
   assign tap_c      = tap_at(cfg.taps, cfg.radius);
   assign width_addr = ADDR_BITS'(cfg.width);
   assign lag_addr   = ADDR_BITS'(cfg.lag);

   assign cprod = $signed({1'b0, tap_c}) * q_data.sample;
   assign vprod = $signed({1'b0, tap_k}) * rd_sample;
   assign hprod = $signed({1'b0, tap_k}) * win_ff[k_ff];

   always_comb begin
      vmag   = vacc_ff[VACC_BITS-1] ? VACC_BITS'(-vacc_ff) : VACC_BITS'(vacc_ff);
      vq     = VQ_BITS'((vmag + VACC_BITS'(1 << (TAP_BITS - 1))) >> TAP_BITS);
      vq_ext = $signed({{(VSUM_BITS - VQ_BITS){1'b0}}, vq});
      vsum   = vacc_ff[VACC_BITS-1] ? -vq_ext : vq_ext;

      hmag   = hacc_ff[HACC_BITS-1] ? HACC_BITS'(-hacc_ff) : HACC_BITS'(hacc_ff);
      hq     = HQ_BITS'((hmag + HACC_BITS'(1 << (TAP_BITS - 1))) >> TAP_BITS);
      hq_ext = $signed({1'b0, hq});

      dmag    = diff_ff[DIFF_BITS-1] ? DIFF_BITS'(-diff_ff) : DIFF_BITS'(diff_ff);
      thr_ext = DIFF_BITS'(cfg.threshold);
      dpos    = $signed(dmag - thr_ext);

      pmag   = prod_ff[PROD_BITS-1] ? PROD_BITS'(-prod_ff) : PROD_BITS'(prod_ff);
      pq     = PQ_BITS'((pmag + PROD_BITS'(1 << (GAIN_FRAC - 1))) >> GAIN_FRAC);
      pq_ext = $signed({2'b00, pq});
      adj    = prod_ff[PROD_BITS-1] ? -pq_ext : pq_ext;
      total  = SUM_BITS'(orig_ff) + adj;
      if (total > SUM_BITS'(32767)) begin
         result = 16'sh7FFF;
      end else if (total < -SUM_BITS'(32768)) begin
         result = 16'sh8000;
      end else begin
         result = total[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      k_in         = k_ff;
      raddr_in     = raddr_ff;
      vacc_in      = vacc_ff;
      hacc_in      = hacc_ff;
      orig_in      = orig_ff;
      blur_in      = blur_ff;
      diff_in      = diff_ff;
      detail_in    = detail_ff;
      prod_in      = prod_ff;
      win_in       = win_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_raddr    = raddr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               ent_in   = q_data;
               vacc_in  = VACC_BITS'(cprod);
               raddr_in = mod_sub(q_data.waddr, width_addr);
               k_in     = WIN_IDX_BITS'(1);
               state_in = (cfg.radius == '0) ? S_VFIN : S_VRD;
            end
         end
         S_VRD: begin
            state_in = S_VMAC;
         end
         S_VMAC: begin
            vacc_in  = vacc_ff + VACC_BITS'(vprod);
            raddr_in = mod_sub(raddr_ff, width_addr);
            k_in     = k_ff + WIN_IDX_BITS'(1);
            state_in = (k_ff == two_r) ? S_VFIN : S_VRD;
         end
         S_VFIN: begin
            win_in[0] = vsum;
            for (int i = 1; i < WIN_LEN; i++) begin
               win_in[i] = win_ff[i-1];
            end
            ram_we   = ent_ff.store;
            state_in = ent_ff.emit ? S_ORD : S_IDLE;
         end
         S_ORD: begin
            ram_raddr = mod_sub(ent_ff.waddr, lag_addr);
            state_in  = S_ODAT;
         end
         S_ODAT: begin
            orig_in = rd_sample;
            if (ent_ff.pass) begin
               detail_in = '0;
               state_in  = S_GMUL;
            end else begin
               hacc_in  = '0;
               k_in     = '0;
               state_in = S_HMAC;
            end
         end
         S_HMAC: begin
            hacc_in  = hacc_ff + HACC_BITS'(hprod);
            k_in     = k_ff + WIN_IDX_BITS'(1);
            state_in = (k_ff == two_r) ? S_HFIN : S_HMAC;
         end
         S_HFIN: begin
            blur_in  = hacc_ff[HACC_BITS-1] ? -hq_ext : hq_ext;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            diff_in  = DIFF_BITS'(orig_ff) - DIFF_BITS'(blur_ff);
            state_in = S_THR;
         end
         S_THR: begin
            if (dmag > thr_ext) begin
               detail_in = diff_ff[DIFF_BITS-1] ? -dpos : dpos;
            end else begin
               detail_in = '0;
            end
            state_in = S_GMUL;
         end
         S_GMUL: begin
            prod_in  = detail_ff * $signed({1'b0, cfg.gain});
            state_in = S_RES;
         end
         S_RES: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_data_in  = result;
               out_last_in  = ent_ff.last;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff      <= ent_in;
      k_ff        <= k_in;
      raddr_ff    <= raddr_in;
      vacc_ff     <= vacc_in;
      hacc_ff     <= hacc_in;
      orig_ff     <= orig_in;
      blur_ff     <= blur_in;
      diff_ff     <= diff_in;
      detail_ff   <= detail_in;
      prod_ff     <= prod_in;
      win_ff      <= win_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_lightness_out = out_data_ff;
   assign rsp_frame_end     = out_last_ff;

endmodule

### hdl/unsharp_mask_lightness.sv
// Unsharp mask on a raster stream of signed Q8.8 lightness samples. A result
// follows its input by R*W+R accepted items (R the clamped radius, W the
// clamped width); feed pad items after the frame to flush the last results,
// and pad items inside the frame are dropped. The front end takes a beat into
// a four-entry queue whenever the queue has room and no register write is
// pending or settling, so input stalls on a waiting result only once the
// queue is full. For each item the back end runs the vertical pass, which
// reads the 2R earlier rows one at a time from the single-read-port line
// store through a multiply-accumulate, plus the horizontal pass, threshold
// and gain when the item releases a result; a pixel within R of an edge
// skips the horizontal pass and threshold. The line store needs no clearing
// after reset. After a register write, input is held off while derived frame
// sizes settle; write registers only between frames.
module unsharp_mask_lightness import uml_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_lightness_in,
   input  logic                          req_pad,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_lightness_out,
   output logic                          rsp_frame_end,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   logic [NEAR_BITS-1:0]   taps_near_ff, taps_middle_ff;
   logic [FAR_BITS-1:0]    taps_far_ff;
   logic [RAD_BITS-1:0]    radius_ff;
   logic [THRESH_BITS-1:0] threshold_ff;
   logic [GAIN_BITS-1:0]   gain_ff;
   logic [DIM_BITS-1:0]    width_ff, height_ff;
   logic [LAG_BITS-1:0]    lag_ff, lag_in;
   logic [POS_BITS-1:0]    size_ff, size_in, end_ff, end_in;
   logic [1:0]             settle_ff, settle_in;

   logic [RAD_BITS-1:0] radius_c;
   logic [DIM_BITS-1:0] width_c, height_c;
   logic                csr_write;

   front_cfg_type fcfg;
   back_cfg_type  bcfg;
   item_type      push_data, pop_data;
   logic          q_push, q_pop, q_full, q_empty;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_near_ff   <= '0;
         taps_middle_ff <= '0;
         taps_far_ff    <= '0;
         radius_ff      <= '0;
         threshold_ff   <= THRESH_BITS'(128);
         gain_ff        <= GAIN_BITS'(2048);
         width_ff       <= DIM_BITS'(1);
         height_ff      <= DIM_BITS'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TAPS_NEAR:   taps_near_ff   <= csr_data[NEAR_BITS-1:0];
            CSR_TAPS_MIDDLE: taps_middle_ff <= csr_data[NEAR_BITS-1:0];
            CSR_TAPS_FAR:    taps_far_ff    <= csr_data[FAR_BITS-1:0];
            CSR_RADIUS:      radius_ff      <= csr_data[RAD_BITS-1:0];
            CSR_THRESHOLD:   threshold_ff   <= csr_data[THRESH_BITS-1:0];
            CSR_GAIN:        gain_ff        <= csr_data[GAIN_BITS-1:0];
            CSR_WIDTH:       width_ff       <= csr_data[DIM_BITS-1:0];
            CSR_HEIGHT:      height_ff      <= csr_data[DIM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      radius_c = (int'(radius_ff) > MAX_RADIUS) ? RAD_BITS'(MAX_RADIUS) : radius_ff;
      if (width_ff == '0) begin
         width_c = DIM_BITS'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         width_c = DIM_BITS'(MAX_WIDTH);
      end else begin
         width_c = width_ff;
      end
      if (height_ff == '0) begin
         height_c = DIM_BITS'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         height_c = DIM_BITS'(MAX_HEIGHT);
      end else begin
         height_c = height_ff;
      end
      lag_in    = LAG_BITS'(width_c) * LAG_BITS'(radius_c) + LAG_BITS'(radius_c);
      size_in   = POS_BITS'(width_c) * POS_BITS'(height_c);
      end_in    = size_ff + POS_BITS'(lag_ff);
      settle_in = (settle_ff != 2'd0) ? settle_ff - 2'd1 : 2'd0;
      if (csr_write) begin
         settle_in = 2'd2;
      end
   end

   always_ff @(posedge clock) begin
      lag_ff  <= lag_in;
      size_ff <= size_in;
      end_ff  <= end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= 2'd2;
      end else begin
         settle_ff <= settle_in;
      end
   end

   always_comb begin
      fcfg.radius    = radius_c;
      fcfg.width     = width_c;
      fcfg.height    = height_c;
      fcfg.lag       = lag_ff;
      fcfg.end_pos   = end_ff;
      bcfg.taps      = {taps_far_ff, taps_middle_ff, taps_near_ff};
      bcfg.radius    = radius_c;
      bcfg.width     = width_c;
      bcfg.lag       = lag_ff;
      bcfg.threshold = threshold_ff;
      bcfg.gain      = gain_ff;
   end

   uml_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (fcfg),
      .hold             ((settle_ff != 2'd0) || csr_valid),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_lightness_in (req_lightness_in),
      .req_pad          (req_pad),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (push_data)
   );

   uml_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   uml_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (bcfg),
      .q_empty           (q_empty),
      .q_data            (pop_data),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_lightness_out (rsp_lightness_out),
      .rsp_frame_end     (rsp_frame_end)
   );

endmodule
